// ----- sv/usfd_pkg.sv -----
// Package for the UPS status frame decoder: frame layout, scaling constants,
// flag masks, the queued frame record and the back-end state type.
// Used by every module of the block; depends on nothing.
package usfd_pkg;

	// Frame layout: the stop byte arrives when the position count reaches FRAME_LAST.
	localparam int FRAME_STORE = 13;
	localparam logic [3:0] FRAME_LAST = 4'd13;
	localparam int POS_IN_V = 1;
	localparam int POS_OUT_V = 2;
	localparam int POS_LOAD = 3;
	localparam int POS_CHARGE = 5;
	localparam int POS_TEMP = 6;
	localparam int POS_FREQ = 7;
	localparam int POS_FLAGS0 = 9;
	localparam int POS_FLAGS1 = 10;
	localparam int POS_FLAGS2 = 11;
	localparam int POS_FLAGS3 = 12;
	localparam logic [8:0] PAIR_SUM = 9'd255;

	// Voltage curve: floor(v*20/23) as v*455920 >> 19, exact for v below 256.
	localparam logic [7:0] VOLT_MIN = 8'd27;
	localparam logic [18:0] VOLT_MUL = 19'd455920;
	localparam logic [7:0] VOLT_OFS = 8'd6;

	// Charge curve.
	localparam logic [7:0] CHG_LO = 8'd160;
	localparam logic [7:0] CHG_HI = 8'd185;
	localparam logic [7:0] CHG_FULL = 8'd100;
	localparam logic [13:0] CHG_MUL = 14'd10000;

	// Temperature curve and raw scale.
	localparam logic [3:0] TEMP_MUL = 4'd10;
	localparam logic [20:0] TEMP_RND = 21'd512;
	localparam logic [11:0] TEMP_OFS = 12'd100;

	// Frequency curve: round(126000 / (v + 32)).
	localparam int DIV_NUM_W = 17;
	localparam int DIV_DEN_W = 9;
	localparam int DIV_Q_W = 12;
	localparam int DIV_CNT_W = 4;
	localparam logic [16:0] FREQ_NUM = 17'd126000;
	localparam logic [8:0] FREQ_OFS = 9'd32;

	// Flag byte masks.
	localparam logic [7:0] FL_ONBATT = 8'h80;
	localparam logic [7:0] FL_LOWBATT = 8'h40;
	localparam logic [7:0] FL_BOOSTTRIM = 8'h84;
	localparam logic [7:0] FL_TEST = 8'h04;
	localparam logic [7:0] FL_BEEP = 8'h01;

	// Status bit positions.
	localparam int ST_ONBATT = 0;
	localparam int ST_LOWBATT = 1;
	localparam int ST_BOOST = 2;
	localparam int ST_TRIM = 3;
	localparam int ST_TEST = 4;
	localparam int ST_OFF = 5;
	localparam int ST_BEEP = 6;

	// Queue between front and back.
	localparam int QDEPTH = 2;
	localparam logic [1:0] QFULL_CNT = 2'd2;

	typedef struct packed {
		logic ok;
		logic [7:0] in_v;
		logic [7:0] out_v;
		logic [7:0] load;
		logic [7:0] charge;
		logic [7:0] temp;
		logic [7:0] freq;
		logic [7:0] flags0;
	} frame_rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL,
		BK_SCALE,
		BK_DIV,
		BK_OUT
	} back_state_t;

endpackage

// ----- sv/usfd_front.sv -----
// Front end of the UPS status frame decoder: counts and stores reply bytes
// and, on the stop byte, checks the complement pairs and queues a frame record.
// Depends on usfd_pkg.
module usfd_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rx_valid,
	output logic                  rx_stall,
	input  logic [7:0]            rx_byte,
	input  logic                  frame_first,
	input  logic                  q_full,
	output logic                  push,
	output usfd_pkg::frame_rec_t  push_rec
);

	logic [3:0] idx_q;
	logic [7:0] frame_q [usfd_pkg::FRAME_STORE];
	logic [3:0] idx_eff;
	logic       accept;
	logic       last;
	logic [8:0] sum_a;
	logic [8:0] sum_b;

	assign rx_stall = q_full;
	assign accept = rx_valid & ~q_full;
	assign idx_eff = frame_first ? 4'd0 : idx_q;
	assign last = (idx_eff >= usfd_pkg::FRAME_LAST);
	assign push = accept & last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 4'd0;
		end else if (accept) begin
			idx_q <= last ? 4'd0 : idx_eff + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !last) begin
			frame_q[idx_eff] <= rx_byte;
		end
	end

	assign sum_a = {1'b0, frame_q[usfd_pkg::POS_FLAGS0]} + {1'b0, frame_q[usfd_pkg::POS_FLAGS1]};
	assign sum_b = {1'b0, frame_q[usfd_pkg::POS_FLAGS2]} + {1'b0, frame_q[usfd_pkg::POS_FLAGS3]};

	always_comb begin
		push_rec.ok = (sum_a == usfd_pkg::PAIR_SUM) && (sum_b == usfd_pkg::PAIR_SUM);
		push_rec.in_v = frame_q[usfd_pkg::POS_IN_V];
		push_rec.out_v = frame_q[usfd_pkg::POS_OUT_V];
		push_rec.load = frame_q[usfd_pkg::POS_LOAD];
		push_rec.charge = frame_q[usfd_pkg::POS_CHARGE];
		push_rec.temp = frame_q[usfd_pkg::POS_TEMP];
		push_rec.freq = frame_q[usfd_pkg::POS_FREQ];
		push_rec.flags0 = frame_q[usfd_pkg::POS_FLAGS0];
	end

endmodule

// ----- sv/usfd_fifo.sv -----
// Two-entry frame record queue between the front and back ends.
// Depends on usfd_pkg.
module usfd_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  usfd_pkg::frame_rec_t  push_rec,
	input  logic                  pop,
	output usfd_pkg::frame_rec_t  head,
	output usfd_pkg::q_stat_t     stat
);

	usfd_pkg::frame_rec_t mem_q [usfd_pkg::QDEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign head = mem_q[rd_ptr_q];
	assign stat.full = (cnt_q == usfd_pkg::QFULL_CNT);
	assign stat.empty = (cnt_q == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

endmodule

// ----- sv/usfd_div.sv -----
// Restoring divider for the frequency curve, one quotient bit per cycle.
// The quotient is known to fit DIV_Q_W bits. Depends on usfd_pkg.
module usfd_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [usfd_pkg::DIV_NUM_W-1:0]   dividend,
	input  logic [usfd_pkg::DIV_DEN_W-1:0]   divisor,
	output logic                             busy,
	output logic [usfd_pkg::DIV_Q_W-1:0]     quotient
);

	logic                            busy_q;
	logic [usfd_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [usfd_pkg::DIV_DEN_W-1:0]  rem_q;
	logic [usfd_pkg::DIV_DEN_W-1:0]  den_q;
	logic [usfd_pkg::DIV_Q_W-1:0]    num_q;
	logic [usfd_pkg::DIV_DEN_W:0]    trial;
	logic [usfd_pkg::DIV_DEN_W:0]    diff;
	logic                            ge;

	assign busy = busy_q;
	assign quotient = num_q;

	// The low dividend bits shift out of num_q as quotient bits shift in.
	assign trial = {rem_q, num_q[usfd_pkg::DIV_Q_W-1]};
	assign diff = trial - {1'b0, den_q};
	assign ge = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= usfd_pkg::DIV_CNT_W'(usfd_pkg::DIV_Q_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - usfd_pkg::DIV_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// The top dividend bits are below any divisor, so they seed the remainder.
			rem_q <= usfd_pkg::DIV_DEN_W'(dividend[usfd_pkg::DIV_NUM_W-1:usfd_pkg::DIV_Q_W]);
			num_q <= dividend[usfd_pkg::DIV_Q_W-1:0];
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[usfd_pkg::DIV_DEN_W-1:0] : trial[usfd_pkg::DIV_DEN_W-1:0];
			num_q <= {num_q[usfd_pkg::DIV_Q_W-2:0], ge};
		end
	end

endmodule

// ----- sv/usfd_back.sv -----
// Back end of the UPS status frame decoder: takes frame records from the queue,
// applies raw or curve scaling, packs status bits and holds the report.
// Depends on usfd_pkg and usfd_div.
module usfd_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  series_mode,
	input  logic                  q_empty,
	input  usfd_pkg::frame_rec_t  q_head,
	output logic                  pop,
	output logic                  rpt_valid,
	input  logic                  rpt_stall,
	output logic                  frame_ok,
	output logic [7:0]            input_volts,
	output logic [7:0]            output_volts,
	output logic [8:0]            load_percent,
	output logic [7:0]            charge_percent,
	output logic [11:0]           temp_tenths,
	output logic [11:0]           freq_tenths,
	output logic [6:0]            status_bits
);

	usfd_pkg::back_state_t state_q;
	usfd_pkg::back_state_t state_nxt;

	usfd_pkg::frame_rec_t rec_q;
	logic [26:0] iv_prod_q;
	logic [26:0] ov_prod_q;
	logic [15:0] tp_sq_q;
	logic [9:0]  ch_sq_q;
	logic [11:0] temp_op_q;
	logic [7:0]  chg_op_q;

	logic        div_start;
	logic        div_busy;
	logic [8:0]  div_den;
	logic [16:0] div_num;
	logic [11:0] div_quot;
	logic        load_rec;
	logic        load_out;

	logic [7:0]  ch_d;
	logic [20:0] t_scaled;
	logic [23:0] c_scaled;
	logic [7:0]  iv_op;
	logic [7:0]  ov_op;
	logic [9:0]  boost_l;
	logic [9:0]  boost_r;
	logic [13:0] mul50_in;
	logic [13:0] mul49_out;
	logic [13:0] mul50_out;
	logic [13:0] mul49_in;
	logic [6:0]  st;

	assign div_den = {1'b0, rec_q.freq} + usfd_pkg::FREQ_OFS;
	assign div_num = usfd_pkg::FREQ_NUM + {9'd0, div_den[8:1]};

	usfd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.busy     (div_busy),
		.quotient (div_quot)
	);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			usfd_pkg::BK_IDLE: begin
				if (!q_empty) begin
					state_nxt = usfd_pkg::BK_MUL;
				end
			end
			usfd_pkg::BK_MUL: begin
				state_nxt = usfd_pkg::BK_SCALE;
			end
			usfd_pkg::BK_SCALE: begin
				state_nxt = usfd_pkg::BK_DIV;
			end
			usfd_pkg::BK_DIV: begin
				if (!div_busy) begin
					state_nxt = usfd_pkg::BK_OUT;
				end
			end
			usfd_pkg::BK_OUT: begin
				if (!rpt_stall) begin
					state_nxt = usfd_pkg::BK_IDLE;
				end
			end
			default: begin
				state_nxt = usfd_pkg::BK_IDLE;
			end
		endcase
	end

	always_comb begin
		pop = 1'b0;
		load_rec = 1'b0;
		div_start = 1'b0;
		load_out = 1'b0;
		rpt_valid = 1'b0;
		unique case (state_q)
			usfd_pkg::BK_IDLE: begin
				pop = ~q_empty;
				load_rec = ~q_empty;
			end
			usfd_pkg::BK_MUL: begin
				div_start = 1'b1;
			end
			usfd_pkg::BK_SCALE: begin
			end
			usfd_pkg::BK_DIV: begin
				load_out = ~div_busy;
			end
			usfd_pkg::BK_OUT: begin
				rpt_valid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= usfd_pkg::BK_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign ch_d = rec_q.charge - usfd_pkg::CHG_LO;
	assign t_scaled = 21'(tp_sq_q) * 21'(usfd_pkg::TEMP_MUL) + usfd_pkg::TEMP_RND;
	assign c_scaled = 24'(ch_sq_q) * 24'(usfd_pkg::CHG_MUL);

	always_ff @(posedge clk) begin
		if (load_rec) begin
			rec_q <= q_head;
		end
		if (state_q == usfd_pkg::BK_MUL) begin
			iv_prod_q <= 27'(rec_q.in_v) * 27'(usfd_pkg::VOLT_MUL);
			ov_prod_q <= 27'(rec_q.out_v) * 27'(usfd_pkg::VOLT_MUL);
			tp_sq_q <= 16'(rec_q.temp) * 16'(rec_q.temp);
			// Only meaningful when the charge byte lies inside the curve's range.
			ch_sq_q <= 10'(ch_d[4:0]) * 10'(ch_d[4:0]);
		end
		if (state_q == usfd_pkg::BK_SCALE) begin
			temp_op_q <= {1'b0, t_scaled[20:10]} + usfd_pkg::TEMP_OFS;
			if (rec_q.charge > usfd_pkg::CHG_HI) begin
				chg_op_q <= usfd_pkg::CHG_FULL;
			end else if (rec_q.charge < usfd_pkg::CHG_LO) begin
				chg_op_q <= 8'd0;
			end else begin
				chg_op_q <= c_scaled[23:16];
			end
		end
	end

	assign iv_op = (rec_q.in_v < usfd_pkg::VOLT_MIN) ? 8'd0 : iv_prod_q[26:19] + usfd_pkg::VOLT_OFS;
	assign ov_op = (rec_q.out_v < usfd_pkg::VOLT_MIN) ? 8'd0 : ov_prod_q[26:19] + usfd_pkg::VOLT_OFS;

	// Boost and trim compare the raw voltages against fixed ratios.
	assign boost_l = {1'b0, rec_q.in_v, 1'b0};
	assign boost_r = {1'b0, rec_q.out_v, 1'b0};
	assign mul50_in = 14'(rec_q.in_v) * 14'd50;
	assign mul49_out = 14'(rec_q.out_v) * 14'd49;
	assign mul50_out = 14'(rec_q.out_v) * 14'd50;
	assign mul49_in = 14'(rec_q.in_v) * 14'd49;

	always_comb begin
		st = 7'd0;
		st[usfd_pkg::ST_ONBATT] = |(rec_q.flags0 & usfd_pkg::FL_ONBATT);
		st[usfd_pkg::ST_LOWBATT] = |(rec_q.flags0 & usfd_pkg::FL_LOWBATT);
		if ((rec_q.flags0 & usfd_pkg::FL_BOOSTTRIM) == 8'd0) begin
			st[usfd_pkg::ST_BOOST] = (boost_l > {2'b0, rec_q.out_v}) && (mul50_in < mul49_out);
			st[usfd_pkg::ST_TRIM] = (boost_r > {2'b0, rec_q.in_v}) && (mul50_out < mul49_in);
		end
		st[usfd_pkg::ST_TEST] = |(rec_q.flags0 & usfd_pkg::FL_TEST);
		st[usfd_pkg::ST_OFF] = (rec_q.flags0 == 8'd0);
		st[usfd_pkg::ST_BEEP] = |(rec_q.flags0 & usfd_pkg::FL_BEEP);
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			frame_ok <= rec_q.ok;
			if (!rec_q.ok) begin
				input_volts <= 8'd0;
				output_volts <= 8'd0;
				load_percent <= 9'd0;
				charge_percent <= 8'd0;
				temp_tenths <= 12'd0;
				freq_tenths <= 12'd0;
				status_bits <= 7'd0;
			end else if (series_mode) begin
				input_volts <= iv_op;
				output_volts <= ov_op;
				load_percent <= {rec_q.load, 1'b0};
				charge_percent <= chg_op_q;
				temp_tenths <= temp_op_q;
				freq_tenths <= div_quot;
				status_bits <= st;
			end else begin
				input_volts <= rec_q.in_v;
				output_volts <= rec_q.out_v;
				load_percent <= {1'b0, rec_q.load};
				charge_percent <= rec_q.charge;
				temp_tenths <= 12'(rec_q.temp) * 12'(usfd_pkg::TEMP_MUL);
				freq_tenths <= {2'b0, rec_q.freq, 2'b0};
				status_bits <= st;
			end
		end
	end

endmodule

// ----- sv/ups_status_frame_decoder.sv -----
// Decodes the 14-byte UPS status reply into one report per frame. Bytes are
// accepted one per clock cycle while rx_stall is low; a byte with frame_first
// set restarts the count at the start position, and the fourteenth byte of a
// count closes the frame. The front end checks the complement flag pairs and
// queues a frame record in a two-entry queue; rx_stall rises only while that
// queue is full. The back end takes a record, runs two multiply steps and a
// restoring divider for the frequency curve, and presents the report, which
// holds on the output until taken. series_mode selects raw or curve scaling and
// is written through the cfg channel, which is always ready.
// Depends on usfd_pkg, usfd_front, usfd_fifo and usfd_back.
module ups_status_frame_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	input  logic        rx_valid,
	output logic        rx_stall,
	input  logic [7:0]  rx_byte,
	input  logic        frame_first,
	output logic        rpt_valid,
	input  logic        rpt_stall,
	output logic        frame_ok,
	output logic [7:0]  input_volts,
	output logic [7:0]  output_volts,
	output logic [8:0]  load_percent,
	output logic [7:0]  charge_percent,
	output logic [11:0] temp_tenths,
	output logic [11:0] freq_tenths,
	output logic [6:0]  status_bits
);

	logic                 series_mode_q;
	logic                 q_push;
	logic                 q_pop;
	usfd_pkg::frame_rec_t q_in;
	usfd_pkg::frame_rec_t q_head;
	usfd_pkg::q_stat_t    q_stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			series_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			series_mode_q <= cfg_data;
		end
	end

	usfd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_valid    (rx_valid),
		.rx_stall    (rx_stall),
		.rx_byte     (rx_byte),
		.frame_first (frame_first),
		.q_full      (q_stat.full),
		.push        (q_push),
		.push_rec    (q_in)
	);

	usfd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_rec (q_in),
		.pop      (q_pop),
		.head     (q_head),
		.stat     (q_stat)
	);

	usfd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.series_mode    (series_mode_q),
		.q_empty        (q_stat.empty),
		.q_head         (q_head),
		.pop            (q_pop),
		.rpt_valid      (rpt_valid),
		.rpt_stall      (rpt_stall),
		.frame_ok       (frame_ok),
		.input_volts    (input_volts),
		.output_volts   (output_volts),
		.load_percent   (load_percent),
		.charge_percent (charge_percent),
		.temp_tenths    (temp_tenths),
		.freq_tenths    (freq_tenths),
		.status_bits    (status_bits)
	);

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("frame record pushed into a full queue");

	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("frame record popped from an empty queue");

	a_marker_no_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(rx_valid && !rx_stall && frame_first) |-> !q_push)
		else $error("first-byte marker closed a frame");

endmodule

// ----- verif/usfd_report_checker.sv -----
// Checker for the UPS status frame decoder: watches the byte, report and
// configuration channels, predicts each report and compares it field by field.
// Depends on usfd_pkg for the frame layout, flag masks and status bit positions.
module usfd_report_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_data,
	input  logic        rx_valid,
	input  logic        rx_stall,
	input  logic [7:0]  rx_byte,
	input  logic        frame_first,
	input  logic        rpt_valid,
	input  logic        rpt_stall,
	input  logic        frame_ok,
	input  logic [7:0]  input_volts,
	input  logic [7:0]  output_volts,
	input  logic [8:0]  load_percent,
	input  logic [7:0]  charge_percent,
	input  logic [11:0] temp_tenths,
	input  logic [11:0] freq_tenths,
	input  logic [6:0]  status_bits,
	output int          fail_count,
	output int          reports_waiting,
	output int          reports_seen,
	output int          good_reports
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic        ok;
		logic [7:0]  in_v;
		logic [7:0]  out_v;
		logic [8:0]  load;
		logic [7:0]  charge;
		logic [11:0] temp;
		logic [11:0] freq;
		logic [6:0]  status;
	} ups_report_t;

	ups_report_t       expected_reports[$];
	logic [12:0][7:0]  frame_buf;
	logic [3:0]        byte_pos;
	logic              op_series;

	function automatic ups_report_t decode_frame(input logic [12:0][7:0] fb, input logic op);
		ups_report_t r;
		int iv, ov, ld, ch, tp, fq, d;
		logic [7:0] f0;
		iv = fb[usfd_pkg::POS_IN_V];
		ov = fb[usfd_pkg::POS_OUT_V];
		ld = fb[usfd_pkg::POS_LOAD];
		ch = fb[usfd_pkg::POS_CHARGE];
		tp = fb[usfd_pkg::POS_TEMP];
		fq = fb[usfd_pkg::POS_FREQ];
		f0 = fb[usfd_pkg::POS_FLAGS0];
		r = '0;
		if (int'(fb[usfd_pkg::POS_FLAGS0]) + int'(fb[usfd_pkg::POS_FLAGS1]) != 255 ||
		    int'(fb[usfd_pkg::POS_FLAGS2]) + int'(fb[usfd_pkg::POS_FLAGS3]) != 255)
			return r;
		r.ok = 1'b1;
		if (op) begin
			r.in_v = (iv < 27) ? 8'd0 : 8'(iv * 20 / 23 + 6);
			r.out_v = (ov < 27) ? 8'd0 : 8'(ov * 20 / 23 + 6);
			r.load = 9'(ld * 2);
			if (ch > 185) begin
				r.charge = 8'd100;
			end else if (ch < 160) begin
				r.charge = 8'd0;
			end else begin
				d = ch - 160;
				r.charge = 8'((d * d * 10000) >> 16);
			end
			r.temp = 12'(((tp * tp * 10 + 512) >> 10) + 100);
			// Round half up: add half the divisor before dividing.
			r.freq = 12'((126000 + (fq + 32) / 2) / (fq + 32));
		end else begin
			r.in_v = 8'(iv);
			r.out_v = 8'(ov);
			r.load = 9'(ld);
			r.charge = 8'(ch);
			r.temp = 12'(tp * 10);
			r.freq = 12'(fq * 4);
		end
		r.status[usfd_pkg::ST_ONBATT] = (f0 & usfd_pkg::FL_ONBATT) != 0;
		r.status[usfd_pkg::ST_LOWBATT] = (f0 & usfd_pkg::FL_LOWBATT) != 0;
		// Boost and trim are only judged when neither on battery nor in test.
		if ((f0 & usfd_pkg::FL_BOOSTTRIM) == 0) begin
			r.status[usfd_pkg::ST_BOOST] = (2 * iv > ov) && (50 * iv < 49 * ov);
			r.status[usfd_pkg::ST_TRIM] = (2 * ov > iv) && (50 * ov < 49 * iv);
		end
		r.status[usfd_pkg::ST_TEST] = (f0 & usfd_pkg::FL_TEST) != 0;
		r.status[usfd_pkg::ST_OFF] = (f0 == 8'd0);
		r.status[usfd_pkg::ST_BEEP] = (f0 & usfd_pkg::FL_BEEP) != 0;
		return r;
	endfunction

	task automatic check_field(input string what, input int want, input int got);
		if (want != got) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		ups_report_t want;
		if (!arst_n) begin
			byte_pos = '0;
			op_series = 1'b0;
			expected_reports.delete();
			reports_waiting = 0;
		end else begin
			if (rpt_valid && !rpt_stall) begin
				reports_seen++;
				if (expected_reports.size() == 0) begin
					fail_count++;
					$display("%0t: report with none expected, frame_ok %0b", $time, frame_ok);
				end else begin
					want = expected_reports.pop_front();
					if (want.ok)
						good_reports++;
					check_field("frame_ok", want.ok, frame_ok);
					check_field("input_volts", want.in_v, input_volts);
					check_field("output_volts", want.out_v, output_volts);
					check_field("load_percent", want.load, load_percent);
					check_field("charge_percent", want.charge, charge_percent);
					check_field("temp_tenths", want.temp, temp_tenths);
					check_field("freq_tenths", want.freq, freq_tenths);
					check_field("status_bits", want.status, status_bits);
				end
			end
			if (cfg_valid && cfg_ready)
				op_series = cfg_data;
			if (rx_valid && !rx_stall) begin
				if (frame_first)
					byte_pos = '0;
				// The word at the last position is the stop byte; it closes the frame.
				if (byte_pos >= usfd_pkg::FRAME_LAST) begin
					expected_reports.push_back(decode_frame(frame_buf, op_series));
					byte_pos = '0;
				end else begin
					frame_buf[byte_pos] = rx_byte;
					byte_pos = byte_pos + 4'd1;
				end
			end
			reports_waiting = expected_reports.size();
		end
	end

endmodule

// ----- verif/ups_status_frame_decoder_tb.sv -----
// Top of the UPS status frame decoder testbench: clock, reset, byte and
// configuration stimulus, report-side stalls and the final verdict.
// Depends on usfd_pkg, ups_status_frame_decoder and usfd_report_checker.
module ups_status_frame_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PHASES = 6;
	localparam int PHASE_BYTES = 325;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_data;
	logic        rx_valid;
	logic        rx_stall;
	logic [7:0]  rx_byte;
	logic        frame_first;
	logic        rpt_valid;
	logic        rpt_stall;
	logic        frame_ok;
	logic [7:0]  input_volts;
	logic [7:0]  output_volts;
	logic [8:0]  load_percent;
	logic [7:0]  charge_percent;
	logic [11:0] temp_tenths;
	logic [11:0] freq_tenths;
	logic [6:0]  status_bits;

	int fail_count;
	int reports_waiting;
	int reports_seen;
	int good_reports;
	int bytes_sent;
	logic steady;
	logic [13:0][7:0] fixed_frame;

	ups_status_frame_decoder u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.rx_valid(rx_valid),
		.rx_stall(rx_stall),
		.rx_byte(rx_byte),
		.frame_first(frame_first),
		.rpt_valid(rpt_valid),
		.rpt_stall(rpt_stall),
		.frame_ok(frame_ok),
		.input_volts(input_volts),
		.output_volts(output_volts),
		.load_percent(load_percent),
		.charge_percent(charge_percent),
		.temp_tenths(temp_tenths),
		.freq_tenths(freq_tenths),
		.status_bits(status_bits)
	);

	usfd_report_checker u_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.rx_valid(rx_valid),
		.rx_stall(rx_stall),
		.rx_byte(rx_byte),
		.frame_first(frame_first),
		.rpt_valid(rpt_valid),
		.rpt_stall(rpt_stall),
		.frame_ok(frame_ok),
		.input_volts(input_volts),
		.output_volts(output_volts),
		.load_percent(load_percent),
		.charge_percent(charge_percent),
		.temp_tenths(temp_tenths),
		.freq_tenths(freq_tenths),
		.status_bits(status_bits),
		.fail_count(fail_count),
		.reports_waiting(reports_waiting),
		.reports_seen(reports_seen),
		.good_reports(good_reports)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("ups_status_frame_decoder verification failed");
		$finish;
	end

	// Report side: mostly short stalls, a few long ones, and long stretches without any.
	initial begin : report_stalls
		int pick;
		int len;
		rpt_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				rpt_stall <= 1'b0;
				len = $urandom_range(1, 8);
			end else if (pick < 90) begin
				rpt_stall <= 1'b1;
				len = $urandom_range(1, 3);
			end else if (pick < 97) begin
				rpt_stall <= 1'b1;
				len = $urandom_range(4, 15);
			end else if (pick < 99) begin
				rpt_stall <= 1'b1;
				len = $urandom_range(30, 80);
			end else begin
				rpt_stall <= 1'b0;
				len = 200;
			end
			repeat (len) @(negedge clk);
		end
	end

	function automatic int sender_gap();
		int pick;
		if (steady)
			return 0;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return 0;
		if (pick < 88)
			return $urandom_range(1, 3);
		if (pick < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] edgy_byte();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			return 8'h00;
		if (pick == 1)
			return 8'hFF;
		return 8'($urandom);
	endfunction

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic send_byte(input logic [7:0] b, input logic first);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			rx_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		frame_first <= first;
		@(posedge clk);
		while (rx_stall)
			@(posedge clk);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_list(input logic [13:0][7:0] fr, input logic marker);
		for (int k = 0; k < 14; k++)
			send_byte(fr[k], (k == 0) && marker);
	endtask

	task automatic send_frame();
		logic [13:0][7:0] fr;
		int lo;
		int hi;
		fr[0] = 8'($urandom);
		fr[usfd_pkg::POS_IN_V] = edgy_byte();
		lo = fr[usfd_pkg::POS_IN_V] / 2;
		hi = fr[usfd_pkg::POS_IN_V] * 2;
		if (hi > 255)
			hi = 255;
		// Output volts near input volts so the boost and trim windows get hit.
		fr[usfd_pkg::POS_OUT_V] = $urandom_range(0, 1) ? 8'($urandom_range(lo, hi)) : edgy_byte();
		fr[usfd_pkg::POS_LOAD] = edgy_byte();
		fr[4] = 8'($urandom);
		fr[usfd_pkg::POS_CHARGE] = $urandom_range(0, 1) ? 8'($urandom_range(150, 195))
			: edgy_byte();
		fr[usfd_pkg::POS_TEMP] = edgy_byte();
		fr[usfd_pkg::POS_FREQ] = edgy_byte();
		fr[8] = 8'($urandom);
		case ($urandom_range(0, 3))
			0: fr[usfd_pkg::POS_FLAGS0] = 8'h00;
			1: fr[usfd_pkg::POS_FLAGS0] = 8'($urandom & $urandom);
			default: fr[usfd_pkg::POS_FLAGS0] = 8'($urandom);
		endcase
		fr[usfd_pkg::POS_FLAGS2] = edgy_byte();
		fr[usfd_pkg::POS_FLAGS1] = ~fr[usfd_pkg::POS_FLAGS0];
		fr[usfd_pkg::POS_FLAGS3] = ~fr[usfd_pkg::POS_FLAGS2];
		if ($urandom_range(0, 9) < 2) begin
			if ($urandom_range(0, 1))
				fr[usfd_pkg::POS_FLAGS1] = fr[usfd_pkg::POS_FLAGS1] ^ 8'(1 << $urandom_range(0, 7));
			else
				fr[usfd_pkg::POS_FLAGS3] = fr[usfd_pkg::POS_FLAGS3] ^ 8'(1 << $urandom_range(0, 7));
		end
		fr[13] = 8'($urandom);
		send_list(fr, $urandom_range(0, 9) != 0);
	endtask

	task automatic wait_idle();
		while (reports_waiting != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_mode(input logic m);
		cfg_valid <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		int target;
		int pick;
		int len;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		rx_valid = 1'b0;
		rx_byte = 8'h00;
		frame_first = 1'b0;
		steady = 1'b0;
		bytes_sent = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			write_mode(ph[0]);
			steady = 1'b0;
			if (ph == 0) begin
				// A started reply cut short, then a marked frame at the upper extremes.
				send_byte(8'h55, 1'b1);
				send_byte(8'hAA, 1'b0);
				fixed_frame = {14{8'hFF}};
				fixed_frame[usfd_pkg::POS_FLAGS0] = 8'h00;
				fixed_frame[usfd_pkg::POS_FLAGS2] = 8'h00;
				send_list(fixed_frame, 1'b1);
			end else if (ph == 1) begin
				fixed_frame = '0;
				fixed_frame[usfd_pkg::POS_FLAGS0] = 8'hFF;
				fixed_frame[usfd_pkg::POS_FLAGS2] = 8'hFF;
				send_list(fixed_frame, 1'b1);
			end
			target = bytes_sent + PHASE_BYTES;
			while (bytes_sent < target) begin
				steady = ($urandom_range(0, 9) == 0);
				pick = $urandom_range(0, 99);
				if (pick < 75) begin
					send_frame();
				end else if (pick < 88) begin
					len = $urandom_range(1, 12);
					for (int k = 0; k < len; k++)
						send_byte(8'($urandom), k == 0);
				end else begin
					len = $urandom_range(1, 10);
					for (int k = 0; k < len; k++)
						send_byte(8'($urandom), $urandom_range(0, 7) == 0);
				end
			end
			rx_valid <= 1'b0;
		end
		wait_idle();

		$display("Sent %0d bytes over %0d phases alternating raw and curve scaling;",
			bytes_sent, PHASES);
		$display("checked %0d reports, %0d of them with a good pair check.",
			reports_seen, good_reports);
		if (fail_count == 0)
			$display("ups_status_frame_decoder verification clean");
		else
			$display("ups_status_frame_decoder verification failed");
		$finish;
	end

endmodule
